/* design/sh24_pkg.sv */
// ----------------------------------------------------------------------------
// sh24_pkg: shared types, constants and round function
// Initialisation constants, the SipRound, command and config structs.
// ----------------------------------------------------------------------------
package sh24_pkg;

  localparam logic [63:0] InitC0 = 64'h736f6d6570736575;
  localparam logic [63:0] InitC1 = 64'h646f72616e646f6d;
  localparam logic [63:0] InitC2 = 64'h6c7967656e657261;
  localparam logic [63:0] InitC3 = 64'h7465646279746573;
  localparam logic [63:0] FinXor = 64'h00000000000000ff;
  localparam int unsigned LenShift  = 56;
  localparam int unsigned FinRounds = 4;
  localparam int unsigned CfgIdxW   = 8;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 8'd1;

  localparam logic [3:0] WordBytes = 4'd8;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } sip_state_t;

  typedef enum logic [1:0] {
    CMD_MSG      = 2'd0,  // compress the word only
    CMD_FIN      = 2'd1,  // compress the tail, then finalise
    CMD_FIN_FULL = 2'd2   // compress the word, then the tail, then finalise
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [63:0] word;
    logic [63:0] tail;
  } cmd_t;

  typedef struct packed {
    logic               we;
    logic [CfgIdxW-1:0] index;
    logic [63:0]        data;
  } cfg_wr_t;

  function automatic sip_state_t key_load(input logic [63:0] k0, input logic [63:0] k1);
    sip_state_t s;
    s.a = k0 ^ InitC0;
    s.b = k1 ^ InitC1;
    s.c = k0 ^ InitC2;
    s.d = k1 ^ InitC3;
    return s;
  endfunction

  function automatic sip_state_t sip_round(input sip_state_t s);
    sip_state_t r;
    r = s;
    r.a = r.a + r.b;
    r.b = {r.b[50:0], r.b[63:51]};
    r.b = r.b ^ r.a;
    r.a = {r.a[31:0], r.a[63:32]};
    r.c = r.c + r.d;
    r.d = {r.d[47:0], r.d[63:48]};
    r.d = r.d ^ r.c;
    r.a = r.a + r.d;
    r.d = {r.d[42:0], r.d[63:43]};
    r.d = r.d ^ r.a;
    r.c = r.c + r.b;
    r.b = {r.b[46:0], r.b[63:47]};
    r.b = r.b ^ r.c;
    r.c = {r.c[31:0], r.c[63:32]};
    return r;
  endfunction

  // byte mask keeping the lowest n bytes
  function automatic logic [63:0] tail_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

/* design/sh24_intf.sv */
// ----------------------------------------------------------------------------
// sh24 channel interfaces
// Valid/ready channels for message words, hash results and key writes.
// ----------------------------------------------------------------------------
interface sh24_msg_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  tail_bytes;
  logic        last;
  modport source (output valid, message_word, tail_bytes, last, input ready);
  modport sink   (input valid, message_word, tail_bytes, last, output ready);
endinterface

interface sh24_hash_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

interface sh24_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/sh24_front.sv */
// ----------------------------------------------------------------------------
// sh24_front: word intake and classification
// Tracks the message length and turns each word into a core command.
// ----------------------------------------------------------------------------
module sh24_front
  import sh24_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfg_wr_t        cfg_i,
  sh24_msg_if.sink       msg_i,
  output cmd_t           cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i
);

  logic [7:0] len_q, len_d;
  logic [3:0] n_sat;
  logic [3:0] len_add;
  logic [7:0] len_new;
  logic       accept;
  logic       key_wr;

  assign msg_i.ready = cmd_ready_i;
  assign cmd_valid_o = msg_i.valid;
  assign accept      = msg_i.valid && cmd_ready_i;
  assign key_wr      = cfg_i.we && (cfg_i.index == RegKeyLow || cfg_i.index == RegKeyHigh);

  always_comb begin
    n_sat   = (msg_i.tail_bytes > WordBytes) ? WordBytes : msg_i.tail_bytes;
    len_add = msg_i.last ? n_sat : WordBytes;
    len_new = len_q + {4'b0000, len_add};

    cmd_o.word = msg_i.message_word;
    cmd_o.tail = '0;
    if (!msg_i.last) begin
      cmd_o.kind = CMD_MSG;
    end else if (n_sat == WordBytes) begin
      cmd_o.kind = CMD_FIN_FULL;
    end else begin
      cmd_o.kind = CMD_FIN;
      cmd_o.tail = msg_i.message_word & tail_mask(n_sat);
    end
    cmd_o.tail[63:LenShift] = len_new;

    len_d = len_q;
    if (key_wr) begin
      len_d = '0;
    end else if (accept) begin
      len_d = msg_i.last ? 8'd0 : len_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

endmodule

/* design/sh24_queue.sv */
// ----------------------------------------------------------------------------
// sh24_queue: command queue
// Small FIFO between intake and core; head is read in place, popped at end.
// ----------------------------------------------------------------------------
module sh24_queue
  import sh24_pkg::*;
#(
  parameter int unsigned Depth = 2  // 2 or more
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  push_i,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  output cmd_t  head_o,
  output logic  head_valid_o,
  input  logic  pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* design/sh24_core.sv */
// ----------------------------------------------------------------------------
// sh24_core: SipRound engine and result register
// One SipRound per cycle over the head command unless stalled on an untaken hash; holds keys and state.
// ----------------------------------------------------------------------------
module sh24_core
  import sh24_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_wr_t    cfg_i,
  input  cmd_t       cmd_i,
  input  logic       cmd_valid_i,
  output logic       cmd_pop_o,
  sh24_hash_if.source hash_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CMP1  = 5'b00010,  // second round of a word
    ST_TAIL0 = 5'b00100,
    ST_TAIL1 = 5'b01000,
    ST_FIN   = 5'b10000
  } core_state_e;

  core_state_e state_q, state_d;
  logic [1:0]  cnt_q, cnt_d;
  sip_state_t  v_q, v_d, rnd_in, rnd_out;
  logic [63:0] key_lo_q, key_lo_d, key_hi_q, key_hi_d;
  logic [63:0] inject, post_a, post_c;
  logic        step, out_load, out_free;
  logic        hv_q, hv_d;
  logic [63:0] hash_q, hash_d;

  assign out_free = !hv_q || hash_o.ready;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    inject    = '0;
    post_a    = '0;
    post_c    = '0;
    step      = 1'b0;
    cmd_pop_o = 1'b0;
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          step = 1'b1;
          if (cmd_i.kind == CMD_FIN) begin
            inject  = cmd_i.tail;
            state_d = ST_TAIL1;
          end else begin
            inject  = cmd_i.word;
            state_d = ST_CMP1;
          end
        end
      end
      ST_CMP1: begin
        step   = 1'b1;
        post_a = cmd_i.word;
        if (cmd_i.kind == CMD_MSG) begin
          cmd_pop_o = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          state_d = ST_TAIL0;
        end
      end
      ST_TAIL0: begin
        step    = 1'b1;
        inject  = cmd_i.tail;
        state_d = ST_TAIL1;
      end
      ST_TAIL1: begin
        step    = 1'b1;
        post_a  = cmd_i.tail;
        post_c  = FinXor;
        cnt_d   = '0;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (cnt_q != 2'(FinRounds - 1) || out_free) begin
          step  = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == 2'(FinRounds - 1)) begin
            out_load  = 1'b1;
            cmd_pop_o = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    rnd_in   = v_q;
    rnd_in.d = v_q.d ^ inject;
    rnd_out  = sip_round(rnd_in);
    hash_d   = rnd_out.a ^ rnd_out.b ^ rnd_out.c ^ rnd_out.d;

    v_d = v_q;
    if (step) begin
      v_d   = rnd_out;
      v_d.a = rnd_out.a ^ post_a;
      v_d.c = rnd_out.c ^ post_c;
    end
    if (out_load) begin
      v_d = key_load(key_lo_q, key_hi_q);
    end

    key_lo_d = key_lo_q;
    key_hi_d = key_hi_q;
    if (cfg_i.we && cfg_i.index == RegKeyLow) begin
      key_lo_d = cfg_i.data;
      v_d      = key_load(key_lo_d, key_hi_d);
    end else if (cfg_i.we && cfg_i.index == RegKeyHigh) begin
      key_hi_d = cfg_i.data;
      v_d      = key_load(key_lo_d, key_hi_d);
    end

    hv_d = hv_q;
    if (out_load) begin
      hv_d = 1'b1;
    end else if (hash_o.ready) begin
      hv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      v_q      <= key_load('0, '0);
      key_lo_q <= '0;
      key_hi_q <= '0;
      hv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      v_q      <= v_d;
      key_lo_q <= key_lo_d;
      key_hi_q <= key_hi_d;
      hv_q     <= hv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      hash_q <= hash_d;
    end
  end

  assign hash_o.valid      = hv_q;
  assign hash_o.hash_value = hash_q;

  // a command under way must stay at the queue head
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> cmd_valid_i)
    else $error("core busy without a queued command");

  // the head leaves only at the end of its work
  a_pop_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == ST_CMP1 || state_q == ST_FIN))
    else $error("command popped mid-sequence");

  // a result never overwrites one not yet taken
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!hv_q || hash_o.ready))
    else $error("hash register overrun");

  // after a hash the state is seeded from the key again
  a_reseed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !cfg_i.we |=> (v_q.a == (key_lo_q ^ InitC0) && v_q.d == (key_hi_q ^ InitC3)))
    else $error("state not reseeded after hash");

endmodule

/* design/siphash_2_4_keyed_hash.sv */
// ----------------------------------------------------------------------------
// siphash_2_4_keyed_hash: keyed SipHash-2-4 over 64-bit message words
// Intake classifies words and tracks length, a queue decouples it from the
// SipRound core, which emits one hash per message.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                 transfer when
//  msg_i     in   message_word[63:0] tail_bytes[3:0] last valid && ready
//  hash_o    out  hash_value[63:0]                        valid && ready
//  cfg_i     in   index[7:0] data[63:0]                   valid && ready
//
//  Rounds: one SipRound per cycle in the core unless stalled. A non-final word is compressed;
//  a final word with 0..7 bytes compresses its tail, one with 8 bytes the word then the tail; both finalise.
//  Reset: keys clear to zero and the state is seeded from them; no sweep.
//  Stalls: the queue (QueueDepth commands) keeps taking words while the core works, until it is full;
//  the core waits on its last round while a hash is still untaken.
//  Key writes always complete at once and reseed the state.
// ----------------------------------------------------------------------------
module siphash_2_4_keyed_hash
  import sh24_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sh24_msg_if.sink     msg_i,
  sh24_hash_if.source  hash_o,
  sh24_cfg_if.sink     cfg_i
);

  cfg_wr_t cfg_wr;
  cmd_t    push_cmd, head_cmd;
  logic    push_valid, push_ready;
  logic    head_valid, head_pop;

  // key writes never stall
  assign cfg_i.ready  = 1'b1;
  assign cfg_wr.we    = cfg_i.valid;
  assign cfg_wr.index = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;

  sh24_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .msg_i       (msg_i),
    .cmd_o       (push_cmd),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready)
  );

  sh24_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_cmd),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .head_o       (head_cmd),
    .head_valid_o (head_valid),
    .pop_i        (head_pop)
  );

  sh24_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .cmd_i       (head_cmd),
    .cmd_valid_i (head_valid),
    .cmd_pop_o   (head_pop),
    .hash_o      (hash_o)
  );

endmodule
